// ===== hdl/rle_register_write_expander_assert.svh =====
// Assertion macros shared by the register-write expander.
`ifndef RLE_REGISTER_WRITE_EXPANDER_ASSERT_SVH
`define RLE_REGISTER_WRITE_EXPANDER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define RLEW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define RLEW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rlew_pkg.sv =====
// Types and constants of the register-write expander.
package rlew_pkg;

    localparam int WORD_W  = 16;
    localparam int COUNT_W = 15;
    localparam int RUN_BIT = 15;

    // Record parser phases, one-hot.
    typedef enum logic [3:0] {
        PH_ADDR  = 4'b0001,
        PH_COUNT = 4'b0010,
        PH_VALUE = 4'b0100,
        PH_COPY  = 4'b1000
    } t_phase;

    // Function codes of an input request.
    localparam logic FUNC_SUPPLY = 1'b0;
    localparam logic FUNC_PULL   = 1'b1;

    typedef struct packed {
        logic              func;
        logic [WORD_W-1:0] word;
    } t_item;

    typedef struct packed {
        logic              vld;
        logic [WORD_W-1:0] addr;
        logic [WORD_W-1:0] data;
        logic              last;
    } t_result;

endpackage

// ===== hdl/rlew_in_stage.sv =====
// Input register of the register-write expander.
module rlew_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  rlew_pkg::t_item i_item,
    input  logic            i_take,
    output logic            o_stall,
    output logic            o_vld,
    output rlew_pkg::t_item o_item
);

    logic            r_vld;
    rlew_pkg::t_item r_item;
    logic            load;

    // The held request leaves when the next stage takes it.
    assign o_stall = r_vld && !i_take;
    assign load    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= load || (r_vld && !i_take);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_item;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

// ===== hdl/rlew_expand.sv =====
// Record parser state and the one-step expansion logic.
module rlew_expand (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  rlew_pkg::t_item   i_item,
    output rlew_pkg::t_result o_res
);

    rlew_pkg::t_phase                r_phase, n_phase;
    logic [rlew_pkg::WORD_W-1:0]     r_target_addr, n_target_addr;
    logic [rlew_pkg::COUNT_W-1:0]    r_remaining, n_remaining;
    logic [rlew_pkg::WORD_W-1:0]     r_repeat_value, n_repeat_value;
    logic [rlew_pkg::COUNT_W-1:0]    rem_dec;
    logic [rlew_pkg::COUNT_W-1:0]    word_count;

    assign rem_dec    = r_remaining - rlew_pkg::COUNT_W'(1);
    assign word_count = i_item.word[rlew_pkg::COUNT_W-1:0];

    always_comb begin
        n_phase        = r_phase;
        n_target_addr  = r_target_addr;
        n_remaining    = r_remaining;
        n_repeat_value = r_repeat_value;
        o_res.vld      = 1'b0;
        o_res.addr     = r_target_addr;
        o_res.data     = r_repeat_value;
        o_res.last     = (rem_dec == '0);
        if (i_go) begin
            if (i_item.func == rlew_pkg::FUNC_PULL) begin
                // A pull only produces a write while a replicated run is owed.
                if ((r_phase == rlew_pkg::PH_ADDR) && (r_remaining != '0)) begin
                    o_res.vld   = 1'b1;
                    n_remaining = rem_dec;
                end
            end else begin
                case (r_phase)
                    rlew_pkg::PH_ADDR: begin
                        // A new address drops whatever is left of a pending run.
                        n_target_addr = i_item.word;
                        n_remaining   = '0;
                        n_phase       = rlew_pkg::PH_COUNT;
                    end
                    rlew_pkg::PH_COUNT: begin
                        n_remaining = word_count;
                        if (i_item.word[rlew_pkg::RUN_BIT]) begin
                            n_phase = rlew_pkg::PH_VALUE;
                        end else if (word_count != '0) begin
                            n_phase = rlew_pkg::PH_COPY;
                        end else begin
                            n_phase = rlew_pkg::PH_ADDR;
                        end
                    end
                    rlew_pkg::PH_VALUE: begin
                        n_repeat_value = i_item.word;
                        n_phase        = rlew_pkg::PH_ADDR;
                    end
                    rlew_pkg::PH_COPY: begin
                        if (r_remaining == '0) begin
                            n_phase = rlew_pkg::PH_ADDR;
                        end else begin
                            o_res.vld   = 1'b1;
                            o_res.data  = i_item.word;
                            n_remaining = rem_dec;
                            if (rem_dec == '0) begin
                                n_phase = rlew_pkg::PH_ADDR;
                            end
                        end
                    end
                    default: begin
                        n_phase = rlew_pkg::PH_ADDR;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= rlew_pkg::PH_ADDR;
            r_target_addr  <= '0;
            r_remaining    <= '0;
            r_repeat_value <= '0;
        end else begin
            r_phase        <= n_phase;
            r_target_addr  <= n_target_addr;
            r_remaining    <= n_remaining;
            r_repeat_value <= n_repeat_value;
        end
    end

endmodule

// ===== hdl/rlew_out_stage.sv =====
// Result register of the register-write expander.
module rlew_out_stage (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rlew_pkg::t_result           i_res,
    input  logic                        i_stall,
    output logic                        o_free,
    output logic                        o_valid,
    output logic [rlew_pkg::WORD_W-1:0] o_addr,
    output logic [rlew_pkg::WORD_W-1:0] o_data,
    output logic                        o_last
);

    logic                        r_vld;
    logic [rlew_pkg::WORD_W-1:0] r_addr;
    logic [rlew_pkg::WORD_W-1:0] r_data;
    logic                        r_last;

    assign o_free = !r_vld || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_free) begin
            r_vld <= i_res.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_res.vld) begin
            r_addr <= i_res.addr;
            r_data <= i_res.data;
            r_last <= i_res.last;
        end
    end

    assign o_valid = r_vld;
    assign o_addr  = r_addr;
    assign o_data  = r_data;
    assign o_last  = r_last;

endmodule

// ===== hdl/rle_register_write_expander.sv =====
// Top level of the compressed register-load stream expander.
//
//   channel   direction  handshake               payload
//   in        request    i_in_valid / o_in_stall i_func, i_word
//   out       result     o_out_valid/i_out_stall o_write_addr, o_write_data, o_run_last
//
// Each request is held in the input register while the parser logic updates its state
// and, when a write results, loads the result register, whose output is the write.
// While the result register is not stalled, requests are accepted back to back.
// Reset is synchronous and active low and returns the parser to the address phase.
// While i_out_stall holds the result register, the input register keeps its request
// and a held request raises o_in_stall until the result is taken.
module rle_register_write_expander (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [15:0] i_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_write_addr,
    output logic [15:0] o_write_data,
    output logic        o_run_last
);

`include "rle_register_write_expander_assert.svh"

    rlew_pkg::t_item   in_item;
    rlew_pkg::t_item   held_item;
    rlew_pkg::t_result step_res;
    logic              held_vld;
    logic              out_free;
    logic              go;

    assign in_item.func = i_func;
    assign in_item.word = i_word;

    // A held request is processed only when the result register can take
    // whatever it produces, so no result is ever dropped.
    assign go = held_vld && out_free;

    rlew_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (in_item),
        .i_take  (go),
        .o_stall (o_in_stall),
        .o_vld   (held_vld),
        .o_item  (held_item)
    );

    // The parser itself: address, count, repeat value, and the word copy phase.
    rlew_expand u_expand (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_item  (held_item),
        .o_res   (step_res)
    );

    rlew_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (step_res),
        .i_stall (i_out_stall),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .o_addr  (o_write_addr),
        .o_data  (o_write_data),
        .o_last  (o_run_last)
    );

    // An accepted request is held in the input register on the next cycle.
    `RLEW_ASSERT_NEXT(a_accept_held, i_in_valid && !o_in_stall, held_vld, "accepted request lost")

    // A held request with a blocked result side must stall the input.
    `RLEW_ASSERT_NOW(a_block_stalls, held_vld && !out_free, o_in_stall, "input not stalled")

    // A processed request with no new one behind it leaves the input register.
    `RLEW_ASSERT_NEXT(a_drain, go && !i_in_valid, !held_vld, "processed request not retired")

    // A result only appears after a request was held for processing.
    `RLEW_ASSERT_NOW(a_result_source, $rose(o_out_valid), $past(held_vld), "stray result")

endmodule
